FILE: rtl/holding_slot_stack_queue_deque_top_assert.svh
// assertion macros used by the back end rtl module of the holding slot block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef HOLDING_SLOT_STACK_QUEUE_DEQUE_TOP_ASSERT_SVH
`define HOLDING_SLOT_STACK_QUEUE_DEQUE_TOP_ASSERT_SVH

// property checked on every clock edge out of reset
`define HSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define HSS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/hss_pkg.sv
// types and constants of the holding slot / stack / queue / deque block
// no dependencies; imported by every rtl module of the block
package hss_pkg;

  // width of a stored identifier
  localparam int ID_BITS = 15;

  // input word codes
  localparam logic [3:0] KIND_ARRIVE = 4'd0;
  localparam logic [3:0] KIND_DEPART = 4'd1;
  localparam logic [3:0] KIND_SPUSH  = 4'd2;
  localparam logic [3:0] KIND_SPOP   = 4'd3;
  localparam logic [3:0] KIND_ENQ    = 4'd4;
  localparam logic [3:0] KIND_DEQ    = 4'd5;
  localparam logic [3:0] KIND_LPUSH  = 4'd6;
  localparam logic [3:0] KIND_RPUSH  = 4'd7;
  localparam logic [3:0] KIND_LPOP   = 4'd8;
  localparam logic [3:0] KIND_RPOP   = 4'd9;
  localparam logic [3:0] KIND_STATUS = 4'd10;

  localparam logic [3:0]  LIMIT_RESET = 4'd5;
  localparam logic [15:0] NONE_ID     = 16'hFFFF;

  typedef enum logic [3:0] {
    OP_ARRIVE,
    OP_DEPART,
    OP_SPUSH,
    OP_SPOP,
    OP_ENQ,
    OP_DEQ,
    OP_LPUSH,
    OP_RPUSH,
    OP_LPOP,
    OP_RPOP,
    OP_STATUS,
    OP_REJECT
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [15:0] car_id;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] held_id;
    logic signed [15:0] stack_top;
    logic [3:0]         stack_count;
    logic signed [15:0] queue_front;
    logic [3:0]         queue_count;
    logic signed [15:0] deque_left;
    logic signed [15:0] deque_right;
    logic [3:0]         deque_count;
  } out_t;

  // classified command handed from front to back
  typedef struct packed {
    op_e                op;
    logic               id_neg;
    logic [ID_BITS-1:0] id;
  } cmd_t;

endpackage

FILE: rtl/hss_front.sv
// front end: decodes input words into commands and buffers two of them
// depends on hss_pkg
module hss_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  input  hss_pkg::in_t  item_i,
  output logic          full_o,
  output logic          cmd_valid_o,
  output hss_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import hss_pkg::*;

  cmd_t       dec;
  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  always_comb begin
    dec.id_neg = item_i.car_id[15];
    dec.id     = ID_BITS'(32'(item_i.car_id[14:0]));
    case (item_i.kind)
      KIND_ARRIVE: dec.op = OP_ARRIVE;
      KIND_DEPART: dec.op = OP_DEPART;
      KIND_SPUSH:  dec.op = OP_SPUSH;
      KIND_SPOP:   dec.op = OP_SPOP;
      KIND_ENQ:    dec.op = OP_ENQ;
      KIND_DEQ:    dec.op = OP_DEQ;
      KIND_LPUSH:  dec.op = OP_LPUSH;
      KIND_RPUSH:  dec.op = OP_RPUSH;
      KIND_LPOP:   dec.op = OP_LPOP;
      KIND_RPOP:   dec.op = OP_RPOP;
      KIND_STATUS: dec.op = OP_STATUS;
      default:     dec.op = OP_REJECT;
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rp_q];
  assign wr_en       = item_valid_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wp_q <= ~wp_q;
      if (rd_en) rp_q <= ~rp_q;
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wp_q] <= dec;
  end

endmodule

FILE: rtl/hss_back.sv
// back end: holding slot, stack, queue and deque state with a two-step sequencer
// depends on hss_pkg and the assertion macro header
`include "holding_slot_stack_queue_deque_top_assert.svh"

module hss_back #(
  parameter int DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [3:0]    cfg_data_i,
  input  logic          cmd_valid_i,
  input  hss_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output hss_pkg::out_t res_o
);
  import hss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  typedef logic [ID_BITS-1:0] id_t;

  bk_state_e         state_q, state_d;
  cmd_t              cmd_q;
  logic [3:0]        limit_q;
  logic              slot_q, slot_d;
  id_t               held_q, held_d;
  id_t               stk_q [DEPTH];
  id_t               stk_d [DEPTH];
  id_t               que_q [DEPTH];
  id_t               que_d [DEPTH];
  id_t               deq_q [DEPTH];
  id_t               deq_d [DEPTH];
  logic [FW-1:0]     sfill_q, sfill_d, qfill_q, qfill_d, dfill_q, dfill_d;
  logic [DEPTH-1:0]  smatch_q, smatch_d, qmatch_q, qmatch_d, dmatch_q, dmatch_d;
  id_t               rpop_q;
  id_t               new_id, cmd_id;
  logic [FW-1:0]     dlast_now, dlast_nxt, lim;
  logic              exec_go, dup, ok_d;
  logic              pop_op, push_op, fill_over;

  function automatic logic [15:0] to16(input id_t v);
    return 16'(32'(v));
  endfunction

  // ---- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (cmd_valid_i) state_d = BK_EXEC;
      BK_EXEC: if (!res_full_i) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i;
    exec_go   = (state_q == BK_EXEC) && !res_full_i;
    res_push_o = exec_go;
  end

  // ---- evaluate step: duplicate compare against every live entry
  assign new_id    = ID_BITS'(32'(cmd_i.id));
  assign dlast_now = dfill_q - FW'(1);

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      smatch_d[k] = (FW'(k) < sfill_q) && (stk_q[k] == new_id);
      qmatch_d[k] = (FW'(k) < qfill_q) && (que_q[k] == new_id);
      dmatch_d[k] = (FW'(k) < dfill_q) && (deq_q[k] == new_id);
    end
  end

  // ---- execute step
  assign cmd_id = ID_BITS'(32'(cmd_q.id));
  assign dup    = (|smatch_q) || (|qmatch_q) || (|dmatch_q);

  always_comb begin
    if (32'(limit_q) > 32'(DEPTH)) lim = FW'(DEPTH);
    else lim = FW'(limit_q);
  end

  always_comb begin
    ok_d    = 1'b0;
    slot_d  = slot_q;
    held_d  = held_q;
    sfill_d = sfill_q;
    qfill_d = qfill_q;
    dfill_d = dfill_q;
    stk_d   = stk_q;
    que_d   = que_q;
    deq_d   = deq_q;
    case (cmd_q.op)
      OP_ARRIVE: begin
        if (!cmd_q.id_neg && !slot_q && !dup) begin
          held_d = cmd_id;
          slot_d = 1'b1;
          ok_d   = 1'b1;
        end
      end
      OP_DEPART: begin
        if (slot_q) begin
          slot_d = 1'b0;
          ok_d   = 1'b1;
        end
      end
      OP_SPUSH: begin
        // top of stack lives in entry zero
        if (slot_q && sfill_q < lim) begin
          for (int k = 1; k < DEPTH; k++) stk_d[k] = stk_q[k-1];
          stk_d[0] = held_q;
          sfill_d  = sfill_q + FW'(1);
          slot_d   = 1'b0;
          ok_d     = 1'b1;
        end
      end
      OP_SPOP: begin
        if (!slot_q && sfill_q != '0) begin
          held_d = stk_q[0];
          for (int k = 0; k < DEPTH - 1; k++) stk_d[k] = stk_q[k+1];
          sfill_d = sfill_q - FW'(1);
          slot_d  = 1'b1;
          ok_d    = 1'b1;
        end
      end
      OP_ENQ: begin
        if (slot_q && qfill_q < lim) begin
          que_d[qfill_q[AW-1:0]] = held_q;
          qfill_d = qfill_q + FW'(1);
          slot_d  = 1'b0;
          ok_d    = 1'b1;
        end
      end
      OP_DEQ: begin
        if (!slot_q && qfill_q != '0) begin
          held_d = que_q[0];
          for (int k = 0; k < DEPTH - 1; k++) que_d[k] = que_q[k+1];
          qfill_d = qfill_q - FW'(1);
          slot_d  = 1'b1;
          ok_d    = 1'b1;
        end
      end
      OP_LPUSH: begin
        if (slot_q && dfill_q < lim) begin
          for (int k = 1; k < DEPTH; k++) deq_d[k] = deq_q[k-1];
          deq_d[0] = held_q;
          dfill_d  = dfill_q + FW'(1);
          slot_d   = 1'b0;
          ok_d     = 1'b1;
        end
      end
      OP_RPUSH: begin
        if (slot_q && dfill_q < lim) begin
          deq_d[dfill_q[AW-1:0]] = held_q;
          dfill_d = dfill_q + FW'(1);
          slot_d  = 1'b0;
          ok_d    = 1'b1;
        end
      end
      OP_LPOP: begin
        if (!slot_q && dfill_q != '0) begin
          held_d = deq_q[0];
          for (int k = 0; k < DEPTH - 1; k++) deq_d[k] = deq_q[k+1];
          dfill_d = dfill_q - FW'(1);
          slot_d  = 1'b1;
          ok_d    = 1'b1;
        end
      end
      OP_RPOP: begin
        // rightmost entry was fetched during the evaluate step
        if (!slot_q && dfill_q != '0) begin
          held_d  = rpop_q;
          dfill_d = dfill_q - FW'(1);
          slot_d  = 1'b1;
          ok_d    = 1'b1;
        end
      end
      OP_STATUS: ok_d = 1'b1;
      OP_REJECT: ok_d = 1'b0;
      default:   ok_d = 1'b0;
    endcase
  end

  // ---- result word from the state after this step
  assign dlast_nxt = dfill_d - FW'(1);

  always_comb begin
    res_o.ok          = ok_d;
    res_o.held_id     = slot_d ? to16(held_d) : NONE_ID;
    res_o.stack_top   = (sfill_d != '0) ? to16(stk_d[0]) : NONE_ID;
    res_o.stack_count = 4'(sfill_d);
    res_o.queue_front = (qfill_d != '0) ? to16(que_d[0]) : NONE_ID;
    res_o.queue_count = 4'(qfill_d);
    res_o.deque_left  = (dfill_d != '0) ? to16(deq_d[0]) : NONE_ID;
    res_o.deque_right = (dfill_d != '0) ? to16(deq_d[dlast_nxt[AW-1:0]]) : NONE_ID;
    res_o.deque_count = 4'(dfill_d);
  end

  // ---- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      limit_q <= LIMIT_RESET;
      slot_q  <= 1'b0;
      held_q  <= '0;
      sfill_q <= '0;
      qfill_q <= '0;
      dfill_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (exec_go) begin
        slot_q  <= slot_d;
        held_q  <= held_d;
        sfill_q <= sfill_d;
        qfill_q <= qfill_d;
        dfill_q <= dfill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q    <= cmd_i;
      smatch_q <= smatch_d;
      qmatch_q <= qmatch_d;
      dmatch_q <= dmatch_d;
      rpop_q   <= deq_q[dlast_now[AW-1:0]];
    end
    if (exec_go) begin
      stk_q <= stk_d;
      que_q <= que_d;
      deq_q <= deq_d;
    end
  end

  // ---- checks
  assign pop_op    = (cmd_q.op == OP_SPOP) || (cmd_q.op == OP_DEQ) ||
                     (cmd_q.op == OP_LPOP) || (cmd_q.op == OP_RPOP);
  assign push_op   = (cmd_q.op == OP_SPUSH) || (cmd_q.op == OP_ENQ) ||
                     (cmd_q.op == OP_LPUSH) || (cmd_q.op == OP_RPUSH);
  assign fill_over = (32'(sfill_q) > 32'(DEPTH)) || (32'(qfill_q) > 32'(DEPTH)) ||
                     (32'(dfill_q) > 32'(DEPTH));

  `HSS_ASSERT(a_exec_done, exec_go |=> (state_q == BK_IDLE), "execute step did not retire")
  `HSS_NEVER(a_push_outside_exec, res_push_o && (state_q != BK_EXEC), "result outside execute")
  `HSS_NEVER(a_fill_over_depth, fill_over, "store fill beyond depth")
  `HSS_ASSERT(a_pop_takes_slot, (exec_go && ok_d && pop_op) |=> slot_q, "pop left slot empty")
  `HSS_ASSERT(a_push_frees_slot, (exec_go && ok_d && push_op) |=> !slot_q, "push left slot full")

endmodule

FILE: rtl/hss_resq.sv
// two-entry result queue between the back end and the result port
// depends on hss_pkg
module hss_resq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hss_pkg::out_t data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output hss_pkg::out_t data_o
);
  import hss_pkg::*;

  out_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr_en, rd_en;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = buf_q[rp_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wp_q <= ~wp_q;
      if (rd_en) rp_q <= ~rp_q;
      case ({wr_en, rd_en})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wp_q] <= data_i;
  end

endmodule

FILE: rtl/holding_slot_stack_queue_deque_top.sv
// top level of the holding slot with bounded stack, queue and deque
// depends on hss_pkg, hss_front, hss_back, hss_resq
//
//   channel   direction  handshake                  word
//   item      in         push / full                hss_pkg::in_t
//   result    out        empty / pop                hss_pkg::out_t
//   config    in         cfg_valid_i / cfg_ready_o  store limit, 4 bits
//
// in the back end each word has an evaluate step, comparing the offered id
// against every live store entry and registering the matches, then an execute
// step that updates state and writes the result word before a new word is taken.
// a two-entry command queue and a two-entry result queue let either side stall;
// a full result queue holds the back end in its update step.
// reset empties the slot and all stores at once, with no clearing pass.
module holding_slot_stack_queue_deque_top #(
  parameter int DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  hss_pkg::in_t  item_i,
  output logic          empty,
  input  logic          pop,
  output hss_pkg::out_t result_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [3:0]    cfg_data_i
);
  import hss_pkg::*;

  logic cmd_valid, cmd_pop, res_full, res_push;
  cmd_t cmd;
  out_t res;

  assign cfg_ready_o = 1'b1;

  hss_front u_front (
    .clk_i,
    .rst_ni,
    .item_valid_i (push),
    .item_i,
    .full_o       (full),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  hss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_data_i,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  hss_resq u_resq (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (result_o)
  );

endmodule

FILE: test/holding_slot_stack_queue_deque_top_test.sv
// self-checking testbench of holding_slot_stack_queue_deque_top
// needs hss_pkg and the block's rtl; a built-in predictor checks every status word
`timescale 1ns / 1ps

module holding_slot_stack_queue_deque_top_test;
  import hss_pkg::*;

  localparam int DEPTH       = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;

  // kind codes that the block does not decode
  localparam logic [3:0] KIND_SPARE_LO = 4'd11;
  localparam logic [3:0] KIND_SPARE_HI = 4'd15;

  typedef struct {
    in_t word;
    bit  drain;   // hold this word back until every status word is back
  } move_t;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  in_t        item_i      = '0;
  logic       empty;
  logic       pop         = 1'b0;
  out_t       result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i  = '0;

  holding_slot_stack_queue_deque_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  move_t pending_moves[$];
  out_t  awaited_status[$];
  int    send_idle_pct  = 0;
  int    recv_stall_pct = 0;
  int    mismatch_count = 0;
  int    cycle_count    = 0;

  // shadow of the slot, the stores and the limit register
  logic [3:0]  limit_reg = LIMIT_RESET;
  logic [14:0] held_val;
  bit          slot_full;
  logic [14:0] stack_mem[DEPTH];
  logic [14:0] queue_mem[DEPTH];
  logic [14:0] deque_mem[DEPTH];
  int          stack_fill, queue_head, queue_fill, deque_head, deque_fill;

  function automatic out_t apply_move(input in_t w);
    out_t        r;
    logic [14:0] id;
    int          lim;
    int          k;
    bit          hit;
    r   = '0;
    id  = w.car_id[14:0];
    lim = (int'(limit_reg) > DEPTH) ? DEPTH : int'(limit_reg);
    case (w.kind)
      KIND_ARRIVE: begin
        hit = 1'b0;
        for (k = 0; k < stack_fill; k++) if (stack_mem[k] == id) hit = 1'b1;
        for (k = 0; k < queue_fill; k++)
          if (queue_mem[(queue_head + k) % DEPTH] == id) hit = 1'b1;
        for (k = 0; k < deque_fill; k++)
          if (deque_mem[(deque_head + k) % DEPTH] == id) hit = 1'b1;
        if (!w.car_id[15] && !slot_full && !hit) begin
          held_val  = id;
          slot_full = 1'b1;
          r.ok      = 1'b1;
        end
      end
      KIND_DEPART: begin
        if (slot_full) begin
          slot_full = 1'b0;
          r.ok      = 1'b1;
        end
      end
      KIND_SPUSH: begin
        if (slot_full && stack_fill < lim) begin
          stack_mem[stack_fill] = held_val;
          stack_fill++;
          slot_full = 1'b0;
          r.ok      = 1'b1;
        end
      end
      KIND_SPOP: begin
        if (!slot_full && stack_fill > 0) begin
          stack_fill--;
          held_val  = stack_mem[stack_fill];
          slot_full = 1'b1;
          r.ok      = 1'b1;
        end
      end
      KIND_ENQ: begin
        if (slot_full && queue_fill < lim) begin
          queue_mem[(queue_head + queue_fill) % DEPTH] = held_val;
          queue_fill++;
          slot_full = 1'b0;
          r.ok      = 1'b1;
        end
      end
      KIND_DEQ: begin
        if (!slot_full && queue_fill > 0) begin
          held_val   = queue_mem[queue_head];
          slot_full  = 1'b1;
          queue_head = (queue_head + 1) % DEPTH;
          queue_fill--;
          r.ok       = 1'b1;
        end
      end
      KIND_LPUSH, KIND_RPUSH: begin
        if (slot_full && deque_fill < lim) begin
          if (w.kind == KIND_LPUSH) begin
            deque_head            = (deque_head + DEPTH - 1) % DEPTH;
            deque_mem[deque_head] = held_val;
          end else begin
            deque_mem[(deque_head + deque_fill) % DEPTH] = held_val;
          end
          deque_fill++;
          slot_full = 1'b0;
          r.ok      = 1'b1;
        end
      end
      KIND_LPOP, KIND_RPOP: begin
        if (!slot_full && deque_fill > 0) begin
          if (w.kind == KIND_LPOP) begin
            held_val   = deque_mem[deque_head];
            deque_head = (deque_head + 1) % DEPTH;
          end else begin
            held_val = deque_mem[(deque_head + deque_fill - 1) % DEPTH];
          end
          slot_full = 1'b1;
          deque_fill--;
          r.ok      = 1'b1;
        end
      end
      KIND_STATUS: r.ok = 1'b1;
      default: r.ok = 1'b0;
    endcase
    r.held_id     = slot_full ? {1'b0, held_val} : NONE_ID;
    r.stack_top   = (stack_fill > 0) ? {1'b0, stack_mem[stack_fill - 1]} : NONE_ID;
    r.stack_count = stack_fill[3:0];
    r.queue_front = (queue_fill > 0) ? {1'b0, queue_mem[queue_head]} : NONE_ID;
    r.queue_count = queue_fill[3:0];
    r.deque_left  = (deque_fill > 0) ? {1'b0, deque_mem[deque_head]} : NONE_ID;
    r.deque_right = (deque_fill > 0) ?
                    {1'b0, deque_mem[(deque_head + deque_fill - 1) % DEPTH]} : NONE_ID;
    r.deque_count = deque_fill[3:0];
    return r;
  endfunction

  // driver: offers the oldest pending word, holds it while full is high
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push   <= 1'b0;
      item_i <= '0;
    end else begin
      if (push && !full) begin
        awaited_status.push_back(apply_move(item_i));
        void'(pending_moves.pop_front());
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (pending_moves.size() != 0 && pending_moves[0].drain &&
                   awaited_status.size() != 0) begin
        push <= 1'b0;
      end else if (pending_moves.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push   <= 1'b1;
        item_i <= pending_moves[0].word;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: takes status words and checks them against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (awaited_status.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("status word with nothing awaited: %p", result_o);
        end else begin
          want = awaited_status.pop_front();
          if (result_o.ok !== want.ok || result_o.held_id !== want.held_id ||
              result_o.stack_top !== want.stack_top ||
              result_o.stack_count !== want.stack_count ||
              result_o.queue_front !== want.queue_front ||
              result_o.queue_count !== want.queue_count ||
              result_o.deque_left !== want.deque_left ||
              result_o.deque_right !== want.deque_right ||
              result_o.deque_count !== want.deque_count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("status mismatch expected: %p", want);
              $display("status mismatch actual:   %p", result_o);
            end
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_move(input logic [3:0] kind, input logic [15:0] id, input bit drain);
    move_t m;
    m.word.kind   = kind;
    m.word.car_id = id;
    m.drain       = drain;
    pending_moves.push_back(m);
  endtask

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(63));
    if (r < 80) begin
      case ($urandom_range(3))
        0:       return 16'h0000;
        1:       return 16'h7FFF;
        2:       return 16'h5555;
        default: return 16'h2AAA;
      endcase
    end
    return 16'($urandom());
  endfunction

  function automatic logic [3:0] push_kind_of(input int s);
    case (s)
      0:       return KIND_SPUSH;
      1:       return KIND_ENQ;
      2:       return KIND_LPUSH;
      default: return KIND_RPUSH;
    endcase
  endfunction

  function automatic logic [3:0] pop_kind_of(input int s);
    case (s)
      0:       return KIND_SPOP;
      1:       return KIND_DEQ;
      2:       return KIND_LPOP;
      default: return KIND_RPOP;
    endcase
  endfunction

  // mostly arrive/push and pop/move pairs, filling and draining in bursts
  task automatic add_random_moves(input int count);
    int  made;
    int  r;
    bit  filling;
    bit  drain;
    made    = 0;
    filling = 1'b1;
    while (made < count) begin
      if ($urandom_range(29) == 0) filling = ~filling;
      drain = ($urandom_range(49) == 0);
      r     = $urandom_range(99);
      if (r < (filling ? 60 : 25)) begin
        add_move(KIND_ARRIVE, pick_id(), drain);
        add_move(push_kind_of($urandom_range(3)), 16'($urandom()), 1'b0);
        made += 2;
      end else if (r < 85) begin
        add_move(pop_kind_of($urandom_range(3)), 16'($urandom()), drain);
        if ($urandom_range(1) == 0)
          add_move(KIND_DEPART, 16'($urandom()), 1'b0);
        else
          add_move(push_kind_of($urandom_range(3)), 16'($urandom()), 1'b0);
        made += 2;
      end else begin
        add_move(4'($urandom_range(15)), 16'($urandom()), drain);
        made += 1;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_moves.size() != 0 || awaited_status.size() != 0 || push)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [3:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = value;
  endtask

  task automatic run_phase(input logic [3:0] limit, input int idle, input int stall,
                           input int count);
    write_limit(limit);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    add_random_moves(count);
    wait_drained();
  endtask

  initial begin
    held_val   = '0;
    slot_full  = 1'b0;
    stack_fill = 0;
    queue_head = 0;
    queue_fill = 0;
    deque_head = 0;
    deque_fill = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset limit, no idling
    add_move(KIND_STATUS,   16'h1234, 1'b0);
    add_move(KIND_DEPART,   16'h0000, 1'b0);   // nothing held
    add_move(KIND_SPOP,     16'h0000, 1'b0);   // every store empty
    add_move(KIND_DEQ,      16'hFFFF, 1'b0);
    add_move(KIND_LPOP,     16'h0000, 1'b0);
    add_move(KIND_RPOP,     16'h0000, 1'b0);
    add_move(KIND_SPUSH,    16'h0000, 1'b0);   // slot empty
    add_move(KIND_ARRIVE,   16'h8000, 1'b0);   // negative ids refused
    add_move(KIND_ARRIVE,   16'hFFFF, 1'b0);
    add_move(KIND_ARRIVE,   16'h0000, 1'b0);
    add_move(KIND_ARRIVE,   16'h7FFF, 1'b0);   // slot occupied
    add_move(KIND_SPOP,     16'h0000, 1'b1);   // slot occupied
    add_move(KIND_SPUSH,    16'h0000, 1'b0);
    add_move(KIND_ARRIVE,   16'h0000, 1'b0);   // already in the stack
    add_move(KIND_ARRIVE,   16'h7FFF, 1'b0);
    add_move(KIND_ENQ,      16'h0000, 1'b0);
    add_move(KIND_ARRIVE,   16'h5555, 1'b0);
    add_move(KIND_LPUSH,    16'h0000, 1'b0);
    add_move(KIND_ARRIVE,   16'h2AAA, 1'b0);
    add_move(KIND_RPUSH,    16'h0000, 1'b0);
    add_move(KIND_SPARE_HI, 16'h7FFF, 1'b0);
    add_move(KIND_SPARE_LO, 16'h0000, 1'b0);
    add_move(KIND_RPOP,     16'h0000, 1'b0);
    add_move(KIND_DEPART,   16'h0000, 1'b0);
    add_move(KIND_DEQ,      16'h0000, 1'b0);
    wait_drained();

    run_phase(4'd0,  0,  0,  60);    // zero limit refuses every push
    run_phase(4'd1,  50, 0,  110);
    run_phase(4'd8,  0,  50, 150);
    run_phase(4'd15, 21, 21, 110);   // above the store depth
    run_phase(4'($urandom_range(15)), 0, 0, 100);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
